@@ src/hcbd_pkg.sv @@
`default_nettype none
package hcbd_pkg;

	localparam int SIZE_BITS_DEF   = 32;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	// Raw input word.
	typedef struct packed {
		logic       new_message;
		logic [7:0] data_byte;
	} raw_t;

	// Decoded output word.
	typedef struct packed {
		logic       body_valid;
		logic [7:0] body_byte;
		logic       message_done;
		logic       size_overflow;
	} dec_t;

	// Classified byte, as passed from the front end through the queue.
	typedef struct packed {
		logic       new_message;
		logic [7:0] data_byte;
		logic       hex_ok;
		logic [3:0] hex_val;
		logic       blank;
		logic       is_cr;
		logic       is_lf;
	} cls_t;

	function automatic cls_t classify(input raw_t w);
		cls_t c;
		c.new_message = w.new_message;
		c.data_byte   = w.data_byte;
		c.hex_ok      = 1'b1;
		c.hex_val     = 4'd0;
		if (w.data_byte >= 8'h30 && w.data_byte <= 8'h39) begin
			c.hex_val = 4'(w.data_byte - 8'h30);
		end else if (w.data_byte >= 8'h61 && w.data_byte <= 8'h66) begin
			c.hex_val = 4'(w.data_byte - 8'h57);
		end else if (w.data_byte >= 8'h41 && w.data_byte <= 8'h46) begin
			c.hex_val = 4'(w.data_byte - 8'h37);
		end else begin
			c.hex_ok = 1'b0;
		end
		c.blank = (w.data_byte == 8'h20) || (w.data_byte >= 8'h09 && w.data_byte <= 8'h0D);
		c.is_cr = (w.data_byte == CHAR_CR);
		c.is_lf = (w.data_byte == CHAR_LF);
		return c;
	endfunction

endpackage
`default_nettype wire

@@ src/hcbd_front.sv @@
`default_nettype none
module hcbd_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              raw_valid,
	output logic             raw_stall,
	input  hcbd_pkg::raw_t   raw_word,
	input  wire              q_full,
	output logic             q_push,
	output hcbd_pkg::cls_t   q_item
);

	logic           valid_s1;
	hcbd_pkg::cls_t item_s1;

	// Hold the classified byte while the queue is full.
	assign raw_stall = valid_s1 && q_full;
	assign q_push    = valid_s1 && !q_full;
	assign q_item    = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!raw_stall) begin
			valid_s1 <= raw_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!raw_stall && raw_valid) begin
			item_s1 <= hcbd_pkg::classify(raw_word);
		end
	end

endmodule
`default_nettype wire

@@ src/hcbd_queue.sv @@
`default_nettype none
module hcbd_queue #(
	parameter int DEPTH = hcbd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  hcbd_pkg::cls_t   push_item,
	output logic             full,
	input  wire              pop,
	output logic             nonempty,
	output hcbd_pkg::cls_t   head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	hcbd_pkg::cls_t mem [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem[rd_ptr_q];

	function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

endmodule
`default_nettype wire

@@ src/hcbd_back.sv @@
`default_nettype none
module hcbd_back #(
	parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              q_nonempty,
	input  hcbd_pkg::cls_t   q_head,
	output logic             q_pop,
	output logic             dec_valid,
	input  wire              dec_stall,
	output hcbd_pkg::dec_t   dec_word
);

	localparam logic [1:0] PH_SIZE  = 2'd0;
	localparam logic [1:0] PH_DATA  = 2'd1;
	localparam logic [1:0] PH_TRAIL = 2'd2;
	localparam logic [1:0] PH_DONE  = 2'd3;

	logic [1:0]           phase_q, phase_d;
	logic [SIZE_BITS-1:0] rem_q, rem_d;
	logic                 dseen_q, dseen_d;
	logic                 dclosed_q, dclosed_d;
	logic                 cr_q, cr_d;
	logic [1:0]           trail_q, trail_d;
	logic                 ovf_q, ovf_d;
	logic                 out_valid_q;
	hcbd_pkg::dec_t       out_q, res;

	// Take the next word whenever the output register is free or draining.
	assign q_pop     = q_nonempty && (!out_valid_q || !dec_stall);
	assign dec_valid = out_valid_q;
	assign dec_word  = out_q;

	always_comb begin
		phase_d   = phase_q;
		rem_d     = rem_q;
		dseen_d   = dseen_q;
		dclosed_d = dclosed_q;
		cr_d      = cr_q;
		trail_d   = trail_q;
		ovf_d     = ovf_q;
		res       = '0;
		if (q_head.new_message) begin
			phase_d   = PH_SIZE;
			rem_d     = '0;
			dseen_d   = 1'b0;
			dclosed_d = 1'b0;
			cr_d      = 1'b0;
			trail_d   = '0;
			ovf_d     = 1'b0;
		end
		unique case (phase_d)
			PH_SIZE: begin
				if (q_head.is_lf && cr_d) begin
					if (dseen_d && rem_d != '0) begin
						phase_d = PH_DATA;
					end else begin
						phase_d          = PH_DONE;
						res.message_done = 1'b1;
					end
					dseen_d   = 1'b0;
					dclosed_d = 1'b0;
					cr_d      = 1'b0;
				end else begin
					cr_d = q_head.is_cr;
					if (!dclosed_d) begin
						if (q_head.hex_ok) begin
							// Saturate once the top nibble is occupied.
							if (rem_d[SIZE_BITS-1 -: 4] != 4'd0) begin
								rem_d = '1;
								ovf_d = 1'b1;
							end else begin
								rem_d = {rem_d[SIZE_BITS-5:0], q_head.hex_val};
							end
							dseen_d = 1'b1;
						end else if (dseen_d || !q_head.blank) begin
							dclosed_d = 1'b1;
						end
					end
				end
			end
			PH_DATA: begin
				if (rem_d != '0) begin
					res.body_valid = 1'b1;
					res.body_byte  = q_head.data_byte;
					rem_d          = rem_d - SIZE_BITS'(1);
				end
				if (rem_d == '0) begin
					phase_d = PH_TRAIL;
					trail_d = 2'd2;
				end
			end
			PH_TRAIL: begin
				if (trail_d <= 2'd1) begin
					trail_d   = '0;
					phase_d   = PH_SIZE;
					rem_d     = '0;
					dseen_d   = 1'b0;
					dclosed_d = 1'b0;
					cr_d      = 1'b0;
				end else begin
					trail_d = trail_d - 2'd1;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
		res.size_overflow = ovf_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIZE;
			rem_q       <= '0;
			dseen_q     <= 1'b0;
			dclosed_q   <= 1'b0;
			cr_q        <= 1'b0;
			trail_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q   <= phase_d;
				rem_q     <= rem_d;
				dseen_q   <= dseen_d;
				dclosed_q <= dclosed_d;
				cr_q      <= cr_d;
				trail_q   <= trail_d;
				ovf_q     <= ovf_d;
			end
			if (q_pop) begin
				out_valid_q <= 1'b1;
			end else if (!dec_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q <= res;
		end
	end

endmodule
`default_nettype wire

@@ src/http_chunked_body_decoder.sv @@
// Path: a word taken on raw_* is registered in the front end, then in the queue,
// and then in the back end's output register, which drives dec_*.
// Throughput: one word per cycle sustained while neither side stalls; the back end
// updates the parser state for one word per cycle, and the queue absorbs short output stalls.
// Reset: arst_n clears the parser (size-line phase, counters, overflow flag),
// the queue pointers and all valid flags; payload registers are not reset.
`default_nettype none
module http_chunked_body_decoder #(
	parameter int SIZE_BITS   = hcbd_pkg::SIZE_BITS_DEF,
	parameter int QUEUE_DEPTH = hcbd_pkg::QUEUE_DEPTH_DEF
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              raw_valid,
	output logic             raw_stall,
	input  hcbd_pkg::raw_t   raw_word,
	output logic             dec_valid,
	input  wire              dec_stall,
	output hcbd_pkg::dec_t   dec_word
);

	// Front end -> queue: classified bytes (hex digit value, blank, CR, LF).
	logic           q_push;
	logic           q_full;
	hcbd_pkg::cls_t q_item;

	// Queue -> back end.
	logic           q_pop;
	logic           q_nonempty;
	hcbd_pkg::cls_t q_head;

	// Classify each raw word in one registered stage.
	hcbd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.raw_valid (raw_valid),
		.raw_stall (raw_stall),
		.raw_word  (raw_word),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_item)
	);

	// Decouple the front end from the back end so each side stalls on its own.
	hcbd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_item),
		.full      (q_full),
		.pop       (q_pop),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	// Run the chunk parser: size line, chunk data, the two bytes after the data, done.
	// Every word produces exactly one output word, held in a register.
	hcbd_back #(
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.dec_valid  (dec_valid),
		.dec_stall  (dec_stall),
		.dec_word   (dec_word)
	);

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none
module testbench;

	localparam int SZ_BITS    = hcbd_pkg::SIZE_BITS_DEF;
	localparam int RAND_WORDS = 1650;
	localparam int QUIET_MAX  = 2000;
	localparam int DRAIN      = 12;
	localparam int DIR_ROWS   = 29;

	typedef enum logic [1:0] {SZ_LINE, CHUNK_DATA, CHUNK_TRAIL, MSG_DONE} parse_ph_t;

	// One stimulus word; typed rows carry an expected decoded word of their own.
	typedef struct packed {
		hcbd_pkg::raw_t word;
		logic           typed;
		hcbd_pkg::dec_t want;
	} stim_t;

	localparam hcbd_pkg::dec_t D_IDLE = '{1'b0, 8'h00, 1'b0, 1'b0};
	localparam hcbd_pkg::dec_t D_DONE = '{1'b0, 8'h00, 1'b1, 1'b0};
	localparam hcbd_pkg::dec_t D_B00  = '{1'b1, 8'h00, 1'b0, 1'b0};
	localparam hcbd_pkg::dec_t D_BFF  = '{1'b1, 8'hFF, 1'b0, 1'b0};

	localparam stim_t DIR_TABLE [DIR_ROWS] = '{
		'{'{1'b1, 8'h20}, 1'b1, D_IDLE},   // leading space right after reset
		'{'{1'b0, 8'h09}, 1'b0, D_IDLE},   // leading tab
		'{'{1'b0, 8'h0D}, 1'b0, D_IDLE},   // CR before any digit arms the line end
		'{'{1'b0, 8'h0A}, 1'b1, D_DONE},   // empty size ends the message
		'{'{1'b0, 8'hFF}, 1'b1, D_IDLE},   // dropped after done
		'{'{1'b1, 8'h32}, 1'b0, D_IDLE},   // new message, size 2
		'{'{1'b0, 8'h3B}, 1'b0, D_IDLE},   // extension closes the digits
		'{'{1'b0, 8'h0A}, 1'b0, D_IDLE},   // bare LF does not end the line
		'{'{1'b0, 8'h0D}, 1'b0, D_IDLE},
		'{'{1'b0, 8'h0A}, 1'b0, D_IDLE},   // enter chunk data
		'{'{1'b0, 8'h00}, 1'b1, D_B00},
		'{'{1'b0, 8'hFF}, 1'b1, D_BFF},
		'{'{1'b0, 8'h5A}, 1'b0, D_IDLE},   // trailer bytes skipped whatever they are
		'{'{1'b0, 8'h0D}, 1'b0, D_IDLE},
		'{'{1'b0, 8'h46}, 1'b0, D_IDLE},   // nine digits: the last one saturates
		'{'{1'b0, 8'h66}, 1'b0, D_IDLE},
		'{'{1'b0, 8'h46}, 1'b0, D_IDLE},
		'{'{1'b0, 8'h66}, 1'b0, D_IDLE},
		'{'{1'b0, 8'h46}, 1'b0, D_IDLE},
		'{'{1'b0, 8'h66}, 1'b0, D_IDLE},
		'{'{1'b0, 8'h46}, 1'b0, D_IDLE},
		'{'{1'b0, 8'h66}, 1'b0, D_IDLE},
		'{'{1'b0, 8'h46}, 1'b0, D_IDLE},
		'{'{1'b0, 8'h0D}, 1'b0, D_IDLE},
		'{'{1'b0, 8'h0A}, 1'b0, D_IDLE},   // saturated chunk begins
		'{'{1'b0, 8'hAA}, 1'b0, D_IDLE},
		'{'{1'b1, 8'h67}, 1'b0, D_IDLE},   // new message, non-hex before any digit
		'{'{1'b0, 8'h0D}, 1'b0, D_IDLE},
		'{'{1'b0, 8'h0A}, 1'b1, D_DONE}    // overflow flag was cleared by new message
	};

	logic           clk;
	logic           arst_n;
	logic           raw_valid;
	logic           raw_stall;
	hcbd_pkg::raw_t raw_word;
	logic           dec_valid;
	logic           dec_stall;
	hcbd_pkg::dec_t dec_word;

	http_chunked_body_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.raw_valid(raw_valid),
		.raw_stall(raw_stall),
		.raw_word (raw_word),
		.dec_valid(dec_valid),
		.dec_stall(dec_stall),
		.dec_word (dec_word)
	);

	// Parser state of the predictor.
	parse_ph_t        ph;
	logic [SZ_BITS-1:0] p_count;
	logic             p_digits;
	logic             p_closed;
	logic             p_cr;
	logic [1:0]       p_trail;
	logic             p_ovf;

	stim_t          stim [$];
	hcbd_pkg::dec_t pending_dec [$];
	bit             pending_nm;
	bit             need_nm;

	logic running;
	int   next_idx;
	int   bus_idx;
	int   n_taken;
	int   n_checked;
	int   n_body;
	int   n_ended;
	int   n_ovf;
	int   n_errors;
	int   n_quiet;
	int   tx_pct;
	int   rx_pct;
	int   bound1;
	int   bound2;
	hcbd_pkg::dec_t got;
	hcbd_pkg::dec_t want;

	function automatic void clear_parser();
		ph       = SZ_LINE;
		p_count  = '0;
		p_digits = 1'b0;
		p_closed = 1'b0;
		p_cr     = 1'b0;
		p_trail  = 2'd0;
		p_ovf    = 1'b0;
	endfunction

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	function automatic bit is_ws(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// Advance the parser by one raw word and return the decoded word it yields.
	function automatic hcbd_pkg::dec_t decode_byte(input hcbd_pkg::raw_t w);
		hcbd_pkg::dec_t r;
		int h;
		logic [7:0] c;
		r = '0;
		c = w.data_byte;
		if (w.new_message)
			clear_parser();
		h = hex_nibble(c);
		case (ph)
			SZ_LINE: begin
				if (c == hcbd_pkg::CHAR_LF && p_cr) begin
					if (p_digits && p_count != 0) begin
						ph = CHUNK_DATA;
					end else begin
						ph = MSG_DONE;
						r.message_done = 1'b1;
					end
					p_digits = 1'b0;
					p_closed = 1'b0;
					p_cr     = 1'b0;
				end else begin
					p_cr = (c == hcbd_pkg::CHAR_CR);
					if (!p_closed) begin
						if (h >= 0) begin
							// saturate once the top nibble is occupied
							if (p_count[SZ_BITS-1 -: 4] != 0) begin
								p_count = '1;
								p_ovf   = 1'b1;
							end else begin
								p_count = {p_count[SZ_BITS-5:0], 4'(h)};
							end
							p_digits = 1'b1;
						end else if (p_digits || !is_ws(c)) begin
							p_closed = 1'b1;
						end
					end
				end
			end
			CHUNK_DATA: begin
				if (p_count != 0) begin
					r.body_valid = 1'b1;
					r.body_byte  = c;
					p_count      = p_count - 1'b1;
				end
				if (p_count == 0) begin
					ph      = CHUNK_TRAIL;
					p_trail = 2'd2;
				end
			end
			CHUNK_TRAIL: begin
				if (p_trail <= 2'd1) begin
					p_trail  = 2'd0;
					ph       = SZ_LINE;
					p_count  = '0;
					p_digits = 1'b0;
					p_closed = 1'b0;
					p_cr     = 1'b0;
				end else begin
					p_trail = p_trail - 2'd1;
				end
			end
			default: ;
		endcase
		r.size_overflow = p_ovf;
		return r;
	endfunction

	// Append one raw word; the first word of a message may carry new_message.
	function automatic void push_word(input logic [7:0] b);
		stim_t s;
		s = '0;
		s.word.new_message = pending_nm;
		s.word.data_byte   = b;
		pending_nm = 1'b0;
		stim.push_back(s);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return 8'h30 + nib;
		return ($urandom_range(1) ? 8'h41 : 8'h61) + (nib - 4'd10);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	function automatic void put_size_line(input logic [31:0] v, input bit no_digits);
		int nd;
		int k;
		logic [7:0] lead [4];
		lead = '{8'h20, 8'h09, 8'h0B, 8'h0C};
		repeat ($urandom_range(2)) push_word(lead[$urandom_range(3)]);
		if (!no_digits) begin
			nd = 1;
			for (k = 1; k < 8; k++)
				if ((v >> (4 * k)) != 0) nd = k + 1;
			repeat ($urandom_range(2)) push_word(8'h30);
			for (k = nd - 1; k >= 0; k--)
				push_word(hex_char(v[4 * k +: 4]));
		end
		// chunk extension, or whitespace after the digits
		if ($urandom_range(4) == 0) begin
			push_word($urandom_range(1) ? 8'h3B : 8'h20);
			repeat ($urandom_range(4)) push_word(8'($urandom_range(8'h7E, 8'h21)));
		end
		push_word(hcbd_pkg::CHAR_CR);
		push_word(hcbd_pkg::CHAR_LF);
	endfunction

	// Build one chunked message, mostly well formed, sometimes broken.
	function automatic void gen_message();
		int n_chunks;
		int sz;
		int k;
		pending_nm = need_nm || ($urandom_range(9) != 0);
		need_nm    = 1'b0;
		n_chunks   = $urandom_range(3);
		for (k = 0; k < n_chunks; k++) begin
			if ($urandom_range(39) == 0) begin
				// oversized chunk: abandon the message part way into its data
				push_word(hex_char(4'($urandom_range(15, 1))));
				repeat ($urandom_range(10, 8)) push_word(hex_char(4'($urandom_range(15))));
				push_word(hcbd_pkg::CHAR_CR);
				push_word(hcbd_pkg::CHAR_LF);
				repeat ($urandom_range(6, 1)) push_word(rand_byte());
				need_nm = 1'b1;
				return;
			end
			sz = ($urandom_range(11) == 0) ? $urandom_range(200, 13) : $urandom_range(12, 1);
			put_size_line(32'(sz), 1'b0);
			repeat (sz) push_word(rand_byte());
			if ($urandom_range(6) == 0) begin
				push_word(rand_byte());
				push_word(rand_byte());
			end else begin
				push_word(hcbd_pkg::CHAR_CR);
				push_word(hcbd_pkg::CHAR_LF);
			end
		end
		put_size_line(32'd0, $urandom_range(3) == 0);
		repeat ($urandom_range(3)) push_word(rand_byte());
		// noise, with new_message at random
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(6, 1)) begin
				pending_nm = ($urandom_range(9) == 0);
				push_word(rand_byte());
			end
			need_nm = 1'b1;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if (running) begin
			n_quiet = n_quiet + 1;
			// check the decoded word against the oldest expectation
			if (dec_valid && !dec_stall) begin
				n_quiet = 0;
				if (pending_dec.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected decoded word: valid=%0d byte=%02h done=%0d ovf=%0d",
							dec_word.body_valid, dec_word.body_byte,
							dec_word.message_done, dec_word.size_overflow);
				end else begin
					want = pending_dec.pop_front();
					n_checked++;
					if (want.body_valid) n_body++;
					if (want.message_done) n_ended++;
					if (want.size_overflow) n_ovf++;
					if (dec_word.body_valid !== want.body_valid ||
						dec_word.body_byte !== want.body_byte ||
						dec_word.message_done !== want.message_done ||
						dec_word.size_overflow !== want.size_overflow) begin
						n_errors++;
						if (n_errors <= 10)
							$display({"mismatch at word %0d: ",
								"want %0d/%02h/%0d/%0d got %0d/%02h/%0d/%0d"},
								n_checked - 1,
								want.body_valid, want.body_byte,
								want.message_done, want.size_overflow,
								dec_word.body_valid, dec_word.body_byte,
								dec_word.message_done, dec_word.size_overflow);
					end
				end
			end
			// predict for the raw word taken at this edge
			if (raw_valid && !raw_stall) begin
				n_quiet = 0;
				got = decode_byte(raw_word);
				pending_dec.push_back(stim[bus_idx].typed ? stim[bus_idx].want : got);
				n_taken++;
			end
			if (n_taken < bound1) begin
				tx_pct = 14;
				rx_pct = 82;
			end else if (n_taken < bound2) begin
				tx_pct = 82;
				rx_pct = 14;
			end else begin
				tx_pct = 0;
				rx_pct = 0;
			end
			// hold a stalled word, otherwise offer the next one or idle
			if (!raw_valid || !raw_stall) begin
				if (next_idx < stim.size() && $urandom_range(99) >= tx_pct) begin
					raw_valid <= 1'b1;
					raw_word  <= stim[next_idx].word;
					bus_idx   = next_idx;
					next_idx++;
				end else begin
					raw_valid <= 1'b0;
				end
			end
			dec_stall <= ($urandom_range(99) < rx_pct);
		end
	end

	initial begin
		arst_n     = 1'b0;
		raw_valid  = 1'b0;
		raw_word   = '0;
		dec_stall  = 1'b0;
		running    = 1'b0;
		next_idx   = 0;
		bus_idx    = 0;
		n_taken    = 0;
		n_checked  = 0;
		n_body     = 0;
		n_ended    = 0;
		n_ovf      = 0;
		n_errors   = 0;
		n_quiet    = 0;
		tx_pct     = 0;
		rx_pct     = 0;
		pending_nm = 1'b0;
		need_nm    = 1'b1;
		clear_parser();
		for (int i = 0; i < DIR_ROWS; i++)
			stim.push_back(DIR_TABLE[i]);
		while (stim.size() < DIR_ROWS + RAND_WORDS)
			gen_message();
		bound1 = (stim.size() + 2 * DIR_ROWS) / 3;
		bound2 = bound1 + (stim.size() - DIR_ROWS) / 3;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		running <= 1'b1;
		@(posedge clk);
		while (n_taken < stim.size() || pending_dec.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (pending_dec.size() != 0) begin
			n_errors++;
			$display("%0d decoded words never arrived", pending_dec.size());
		end
		$display("run: %0d raw words in, %0d decoded words checked,",
			n_taken, n_checked);
		$display("run: %0d body bytes, %0d messages ended, %0d words with overflow set",
			n_body, n_ended, n_ovf);
		if (n_errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	// End the run if no word moves on either side for too long.
	initial begin
		@(posedge clk);
		while (n_quiet < QUIET_MAX)
			@(posedge clk);
		$display("watchdog: no word moved for %0d cycles", QUIET_MAX);
		$display("testbench: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
src/hcbd_pkg.sv
src/hcbd_front.sv
src/hcbd_queue.sv
src/hcbd_back.sv
src/http_chunked_body_decoder.sv
test/testbench.sv
